>>> hdl/i2cme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared codes, widths and item/result types.
// ----------------------------------------------------------------------------
package i2cme_pkg;

	localparam int BitsPerByte = 8;
	localparam int HalfW       = 16;
	localparam int InDataW     = 16;  // 11 used bits, padded to bytes
	localparam int OutDataW    = 24;  // 17 used bits, padded to bytes

	// command codes
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP  = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	// bus status codes
	localparam logic [1:0] ST_NOINIT = 2'd0;
	localparam logic [1:0] ST_READY  = 2'd1;
	localparam logic [1:0] ST_BUSY   = 2'd2;

	// config register indexes
	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_HALF   = 1'b1;

	typedef struct packed {
		logic                   tick;
		logic [2:0]             mode;
		logic [BitsPerByte-1:0] tx_data;
		logic                   send_ack;
		logic                   sda_in;
	} item_t;

	typedef struct packed {
		logic                   scl_out;
		logic                   sda_out;
		logic                   sda_drive;
		logic                   cmd_ready;
		logic                   done_res;
		logic [BitsPerByte-1:0] rx_data;
		logic                   ack_seen;
		logic                   rejected;
		logic [1:0]             bus_state;
	} result_t;

endpackage

>>> hdl/i2cme_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine core
// Bus sequencer state, config registers and the per-item next-state logic.
// ----------------------------------------------------------------------------
module i2cme_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  i2cme_pkg::item_t               item,
	input  logic                           cfg_we,
	input  logic                           cfg_idx,
	input  logic [i2cme_pkg::HalfW-1:0]    cfg_wdata,
	output i2cme_pkg::result_t             res
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_ST_A   = 4'd1;
	localparam logic [3:0] PH_ST_B   = 4'd2;
	localparam logic [3:0] PH_SP_A   = 4'd3;
	localparam logic [3:0] PH_SP_B   = 4'd4;
	localparam logic [3:0] PH_WR_HI  = 4'd5;
	localparam logic [3:0] PH_WR_LO  = 4'd6;
	localparam logic [3:0] PH_WR_AHI = 4'd7;
	localparam logic [3:0] PH_WR_ALO = 4'd8;
	localparam logic [3:0] PH_RD_HI  = 4'd9;
	localparam logic [3:0] PH_RD_LO  = 4'd10;
	localparam logic [3:0] PH_RD_AHI = 4'd11;
	localparam logic [3:0] PH_RD_ALO = 4'd12;

	localparam int BW = i2cme_pkg::BitsPerByte;
	localparam int HW = i2cme_pkg::HalfW;

	logic [3:0]    phase_q, phase_d;
	logic [3:0]    bit_cnt_q, bit_cnt_d;
	logic [HW-1:0] wait_q, wait_d;
	logic [BW-1:0] shift_q, shift_d;
	logic [1:0]    status_q, status_d;
	logic          ack_q, ack_d;
	logic          nack_q, nack_d;
	logic          scl_q, scl_d;
	logic          sda_q, sda_d;
	logic          oe_q, oe_d;
	logic [BW-1:0] rx_q, rx_d;
	logic          en_q, en_d;
	logic [HW-1:0] half_q, half_d;

	logic [HW-1:0] wait_load;
	logic [HW-1:0] wait_dec;
	logic [3:0]    bit_inc;
	logic          done, rej;

	assign wait_load = (half_q == '0) ? HW'(1) : half_q;
	assign wait_dec  = (wait_q != '0) ? wait_q - HW'(1) : '0;
	assign bit_inc   = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		wait_d    = wait_q;
		shift_d   = shift_q;
		status_d  = status_q;
		ack_d     = ack_q;
		nack_d    = nack_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		oe_d      = oe_q;
		rx_d      = rx_q;
		en_d      = en_q;
		half_d    = half_q;
		done      = 1'b0;
		rej       = 1'b0;

		if (cfg_we) begin
			if (cfg_idx == i2cme_pkg::CFG_ENABLE) begin
				if (!cfg_wdata[0] || !en_q) begin
					// disable, or fresh enable: both start from a clean state
					en_d      = cfg_wdata[0];
					phase_d   = PH_IDLE;
					bit_cnt_d = '0;
					wait_d    = '0;
					shift_d   = '0;
					ack_d     = 1'b0;
					nack_d    = 1'b0;
					rx_d      = '0;
					scl_d     = 1'b1;
					sda_d     = 1'b1;
					oe_d      = cfg_wdata[0];
					status_d  = cfg_wdata[0] ? i2cme_pkg::ST_READY : i2cme_pkg::ST_NOINIT;
				end
			end else begin
				half_d = cfg_wdata;
			end
		end else if (step) begin
			if (phase_q == PH_IDLE) begin
				if (item.mode == i2cme_pkg::MODE_START) begin
					if (!en_q || status_q != i2cme_pkg::ST_READY) begin
						rej = 1'b1;
					end else begin
						status_d = i2cme_pkg::ST_BUSY;
						oe_d     = 1'b1;
						sda_d    = 1'b1;
						scl_d    = 1'b1;
						wait_d   = wait_load;
						phase_d  = PH_ST_A;
					end
				end else if (en_q) begin
					if (item.mode == i2cme_pkg::MODE_STOP) begin
						oe_d    = 1'b1;
						sda_d   = 1'b0;
						scl_d   = 1'b1;
						wait_d  = wait_load;
						phase_d = PH_SP_A;
					end else if (item.mode == i2cme_pkg::MODE_WRITE) begin
						sda_d     = item.tx_data[BW-1];
						shift_d   = {item.tx_data[BW-2:0], 1'b0};
						bit_cnt_d = '0;
						scl_d     = 1'b1;
						wait_d    = wait_load;
						phase_d   = PH_WR_HI;
					end else if (item.mode == i2cme_pkg::MODE_READ) begin
						oe_d      = 1'b0;
						shift_d   = '0;
						bit_cnt_d = '0;
						nack_d    = ~item.send_ack;
						scl_d     = 1'b1;
						wait_d    = wait_load;
						phase_d   = PH_RD_HI;
					end
				end
			end else if (item.tick) begin
				wait_d = wait_dec;
				if (wait_dec == '0) begin
					unique case (phase_q)
						PH_ST_A: begin
							sda_d   = 1'b0;
							wait_d  = wait_load;
							phase_d = PH_ST_B;
						end
						PH_ST_B: begin
							scl_d   = 1'b0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
						PH_SP_A: begin
							sda_d   = 1'b1;
							wait_d  = wait_load;
							phase_d = PH_SP_B;
						end
						PH_SP_B: begin
							status_d = i2cme_pkg::ST_READY;
							phase_d  = PH_IDLE;
							done     = 1'b1;
						end
						PH_WR_HI: begin
							scl_d   = 1'b0;
							wait_d  = wait_load;
							phase_d = PH_WR_LO;
						end
						PH_WR_LO: begin
							bit_cnt_d = bit_inc;
							scl_d     = 1'b1;
							wait_d    = wait_load;
							if (bit_inc < 4'(BW)) begin
								sda_d   = shift_q[BW-1];
								shift_d = {shift_q[BW-2:0], 1'b0};
								phase_d = PH_WR_HI;
							end else begin
								oe_d    = 1'b0;
								phase_d = PH_WR_AHI;
							end
						end
						PH_WR_AHI: begin
							ack_d   = ~item.sda_in;
							scl_d   = 1'b0;
							wait_d  = wait_load;
							phase_d = PH_WR_ALO;
						end
						PH_WR_ALO: begin
							oe_d    = 1'b1;
							sda_d   = 1'b0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
						PH_RD_HI: begin
							shift_d = {shift_q[BW-2:0], item.sda_in};
							scl_d   = 1'b0;
							wait_d  = wait_load;
							phase_d = PH_RD_LO;
						end
						PH_RD_LO: begin
							bit_cnt_d = bit_inc;
							scl_d     = 1'b1;
							wait_d    = wait_load;
							if (bit_inc < 4'(BW)) begin
								phase_d = PH_RD_HI;
							end else begin
								rx_d    = shift_q;
								oe_d    = 1'b1;
								sda_d   = nack_q;
								phase_d = PH_RD_AHI;
							end
						end
						PH_RD_AHI: begin
							scl_d   = 1'b0;
							wait_d  = wait_load;
							phase_d = PH_RD_ALO;
						end
						PH_RD_ALO: begin
							sda_d   = 1'b0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
						default: phase_d = PH_IDLE;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			wait_q    <= '0;
			shift_q   <= '0;
			status_q  <= i2cme_pkg::ST_NOINIT;
			ack_q     <= 1'b0;
			nack_q    <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			oe_q      <= 1'b0;
			rx_q      <= '0;
			en_q      <= 1'b0;
			half_q    <= HW'(5);
		end else begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			wait_q    <= wait_d;
			shift_q   <= shift_d;
			status_q  <= status_d;
			ack_q     <= ack_d;
			nack_q    <= nack_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			oe_q      <= oe_d;
			rx_q      <= rx_d;
			en_q      <= en_d;
			half_q    <= half_d;
		end
	end

	// result reflects the state after this item
	always_comb begin
		res.scl_out   = scl_d;
		res.sda_out   = sda_d;
		res.sda_drive = oe_d;
		res.cmd_ready = (phase_d == PH_IDLE) && en_d;
		res.done_res  = done;
		res.rx_data   = rx_d;
		res.ack_seen  = ack_d;
		res.rejected  = rej;
		res.bus_state = status_d;
	end

endmodule

>>> hdl/i2cme_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine output buffer
// Two-entry output register with skid slot.
// ----------------------------------------------------------------------------
module i2cme_out_buf #(
	parameter int DataW = i2cme_pkg::OutDataW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [DataW-1:0] push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [DataW-1:0] out_data
);

	logic             main_vld_q;
	logic             skid_vld_q;
	logic [DataW-1:0] main_q;
	logic [DataW-1:0] skid_q;

	assign can_push  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q || out_ready) begin
				// main slot frees up: refill from skid first, then input
				if (skid_vld_q) begin
					main_vld_q <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					main_vld_q <= push;
				end
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || out_ready) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

>>> hdl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// Results are registered in the output buffer before they reach m_tdata.
// Throughput: one item per cycle; s_tready only drops when the two-entry
//   output buffer is full under downstream backpressure.
// Reset (arst_n low): bus released, SCL and SDA high, SDA undriven, engine
//   disabled, half period 5 ticks, output buffer empty.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, write byte and read byte sequencing.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	// input item: tick[0], tx_data[8:1], send_ack[9], sda_in[10], zero pad
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [i2cme_pkg::InDataW-1:0]     s_tdata,
	// command kind: mode[2:0]
	input  logic [2:0]                        s_tuser,
	// result item: scl_out[0], sda_out[1], sda_drive[2], cmd_ready[3],
	// done_res[4], rx_data[12:5], ack_seen[13], rejected[14],
	// bus_state[16:15], zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [i2cme_pkg::OutDataW-1:0]    m_tdata,
	// config: index 0 enable, index 1 half_period_ticks
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [i2cme_pkg::HalfW-1:0]       cfg_data
);

	localparam int BW = i2cme_pkg::BitsPerByte;

	i2cme_pkg::item_t   item;
	i2cme_pkg::result_t res;
	logic               step;
	logic [i2cme_pkg::OutDataW-1:0] res_data;

	// config always writable; user must make writes only while idle
	assign cfg_ready = 1'b1;

	// an input transfer steps the sequencer unless a cfg write coincides
	assign step = s_tvalid && s_tready;

	assign item.tick     = s_tdata[0];
	assign item.mode     = s_tuser;
	assign item.tx_data  = s_tdata[BW:1];
	assign item.send_ack = s_tdata[BW+1];
	assign item.sda_in   = s_tdata[BW+2];

	i2cme_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.res       (res)
	);

	// pack result fields, highest first, zero pad on top
	assign res_data = {7'd0, res.bus_state, res.rejected, res.ack_seen, res.rx_data,
		res.done_res, res.cmd_ready, res.sda_drive, res.sda_out, res.scl_out};

	i2cme_out_buf #(
		.DataW (i2cme_pkg::OutDataW)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (res_data),
		.can_push  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
